// File: rtl/ict_pkg.sv
// Shared constants, status codes and types of the inode cache table.
package ict_pkg;

	// Table geometry.
	localparam int SLOTS            = 64;
	localparam int SLOT_W           = $clog2(SLOTS);
	localparam int INODES_PER_BLOCK = 8;
	localparam int OFF_W            = $clog2(INODES_PER_BLOCK);

	// Field widths of the transactions.
	localparam int CNT_W      = 16;
	localparam int DEV_W      = 8;
	localparam int INO_W      = 32;
	localparam int BLK_W      = 32;
	localparam int STAT_W     = 3;
	localparam int SLOT_OUT_W = 6;

	// Operation codes.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_HIT   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_ALLOC = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_HELD  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_CLEAN = 3'd4;
	localparam logic [STAT_W-1:0] STAT_WRITE = 3'd5;

	// One slot of the table as held in memory.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             dirty;
		logic [DEV_W-1:0] device;
		logic [INO_W-1:0] inode;
	} ict_entry_t;

	// Read request to the slot memory.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} ict_rd_t;

	// Write request to the slot memory.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		ict_entry_t        data;
	} ict_wr_t;

	// Finished result handed from the controller to the output stage.
	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [DEV_W-1:0]      device;
		logic [INO_W-1:0]      inode;
		logic                  with_block;
	} ict_res_t;

endpackage

// File: rtl/ict_mem.sv
// Slot memory: one synchronous read port, one write port and per-slot valid bits.
module ict_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  ict_pkg::ict_rd_t    rd,
	input  ict_pkg::ict_wr_t    wr,
	output ict_pkg::ict_entry_t rd_data
);
	import ict_pkg::*;

	ict_entry_t       mem_q [SLOTS];
	ict_entry_t       rdat_q;
	logic [SLOTS-1:0] vld_q;
	logic             rvld_q;

	// Storage array with registered read data.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdat_q <= mem_q[rd.addr];
		end
	end

	// Valid bits: a slot never written reads with a zero count and a clean mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rvld_q <= vld_q[rd.addr];
			end
		end
	end

	// Mask the reset-valued fields of an unwritten slot.
	always_comb begin
		rd_data = rdat_q;
		if (!rvld_q) begin
			rd_data.count = '0;
			rd_data.dirty = 1'b0;
		end
	end

endmodule

// File: rtl/ict_ctrl.sv
// Sequencer: scans the slot memory for a get and reads, modifies and writes back a slot for a put.
module ict_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [ict_pkg::DEV_W-1:0]          device_id,
	input  logic [ict_pkg::INO_W-1:0]          inode_number,
	input  logic [ict_pkg::SLOT_OUT_W-1:0]     slot_index,
	input  logic                               mark_dirty,
	output ict_pkg::ict_rd_t                   rd,
	output ict_pkg::ict_wr_t                   wr,
	input  ict_pkg::ict_entry_t                rd_data,
	output logic                               res_valid,
	output ict_pkg::ict_res_t                  res,
	input  logic                               res_take
);
	import ict_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_PUT  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [SLOT_W:0]   ISS_END   = (SLOT_W+1)'(SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	logic [1:0]        state_q;
	logic [SLOT_W:0]   iss_q;
	logic              free_vld_q;
	logic [SLOT_W-1:0] chk_q;
	logic [SLOT_W-1:0] free_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DEV_W-1:0]  dev_q;
	logic [INO_W-1:0]  ino_q;
	logic              dirty_q;
	ict_res_t          res_q;
	ict_res_t          res_d;
	ict_res_t          res_oob;

	logic              slot_oob;
	logic              issuing;
	logic              hit;
	logic              is_free;
	logic              last;
	logic              fin;
	logic [SLOT_W-1:0] alloc_addr;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic              dirty_or;

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// A put naming a slot beyond the table changes nothing.
	assign slot_oob = (32'(slot_index) >= 32'(SLOTS));
	assign issuing  = (iss_q != ISS_END);

	// Result of a put beyond the table: released clean with only the slot filled in.
	always_comb begin
		res_oob        = '0;
		res_oob.status = STAT_CLEAN;
		res_oob.slot   = slot_index;
	end

	// Checks on the slot whose data has just come back from memory.
	assign hit        = (rd_data.count != '0) && (rd_data.device == dev_q) &&
		(rd_data.inode == ino_q);
	assign is_free    = (rd_data.count == '0);
	assign last       = (chk_q == LAST_SLOT);
	assign alloc_addr = free_vld_q ? free_q : chk_q;
	assign cnt_inc    = (rd_data.count == '1) ? rd_data.count : rd_data.count + 1'b1;
	assign cnt_dec    = (rd_data.count == '0) ? '0 : rd_data.count - 1'b1;
	assign dirty_or   = rd_data.dirty | dirty_q;

	// Read address: the first read goes out as the transaction is accepted.
	always_comb begin
		rd = '0;
		unique case (state_q)
			S_IDLE: begin
				rd.en   = in_valid;
				rd.addr = (operation == OP_GET) ? '0 : SLOT_W'(slot_index);
			end
			S_SCAN: begin
				rd.en   = issuing;
				rd.addr = iss_q[SLOT_W-1:0];
			end
			default: begin
				rd = '0;
			end
		endcase
	end

	// Write-back and result for the slot under examination.
	always_comb begin
		wr    = '0;
		res_d = '0;
		fin   = 1'b0;
		unique case (state_q)
			S_SCAN: begin
				if (hit) begin
					wr.en         = 1'b1;
					wr.addr       = chk_q;
					wr.data       = rd_data;
					wr.data.count = cnt_inc;
					res_d.status  = STAT_HIT;
					res_d.slot    = SLOT_OUT_W'(chk_q);
					res_d.device  = dev_q;
					res_d.inode   = ino_q;
					fin           = 1'b1;
				end else if (last) begin
					fin = 1'b1;
					if (free_vld_q || is_free) begin
						wr.en            = 1'b1;
						wr.addr          = alloc_addr;
						wr.data.count    = CNT_W'(1);
						wr.data.dirty    = 1'b0;
						wr.data.device   = dev_q;
						wr.data.inode    = ino_q;
						res_d.status     = STAT_ALLOC;
						res_d.slot       = SLOT_OUT_W'(alloc_addr);
						res_d.device     = dev_q;
						res_d.inode      = ino_q;
						res_d.with_block = 1'b1;
					end else begin
						res_d.status = STAT_FULL;
					end
				end
			end
			S_PUT: begin
				fin           = 1'b1;
				wr.en         = 1'b1;
				wr.addr       = slot_q;
				wr.data       = rd_data;
				wr.data.count = cnt_dec;
				res_d.slot    = SLOT_OUT_W'(slot_q);
				res_d.device  = rd_data.device;
				res_d.inode   = rd_data.inode;
				if (cnt_dec != '0) begin
					wr.data.dirty = dirty_or;
					res_d.status  = STAT_HELD;
				end else if (dirty_or) begin
					wr.data.dirty    = 1'b0;
					res_d.status     = STAT_WRITE;
					res_d.with_block = 1'b1;
				end else begin
					wr.data.dirty = 1'b0;
					res_d.status  = STAT_CLEAN;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			iss_q      <= '0;
			free_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (operation == OP_GET) begin
							state_q    <= S_SCAN;
							iss_q      <= (SLOT_W+1)'(1);
							free_vld_q <= 1'b0;
						end else if (slot_oob) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_PUT;
						end
					end
				end
				S_SCAN: begin
					if (issuing) begin
						iss_q <= iss_q + 1'b1;
					end
					if (is_free) begin
						free_vld_q <= 1'b1;
					end
					if (fin) begin
						state_q <= S_DONE;
					end
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Captured transaction, scan position and finished result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dev_q   <= device_id;
					ino_q   <= inode_number;
					slot_q  <= SLOT_W'(slot_index);
					dirty_q <= mark_dirty;
					chk_q   <= '0;
					res_q   <= (operation == OP_PUT) ? res_oob : '0;
				end
			end
			S_SCAN: begin
				chk_q <= iss_q[SLOT_W-1:0];
				if (is_free && !free_vld_q) begin
					free_q <= chk_q;
				end
				if (fin) begin
					res_q <= res_d;
				end
			end
			S_PUT: begin
				res_q <= res_d;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

// File: rtl/ict_out.sv
// Output register: works out the inode table block and offset and holds the result transaction.
module ict_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           res_valid,
	input  ict_pkg::ict_res_t              res,
	output logic                           res_take,
	input  logic [ict_pkg::BLK_W-1:0]      table_start,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ict_pkg::STAT_W-1:0]     status,
	output logic [ict_pkg::SLOT_OUT_W-1:0] slot_out,
	output logic [ict_pkg::DEV_W-1:0]      device_out,
	output logic [ict_pkg::INO_W-1:0]      inode_out,
	output logic [ict_pkg::BLK_W-1:0]      disk_block,
	output logic [ict_pkg::OFF_W-1:0]      block_offset
);
	import ict_pkg::*;

	logic                  out_valid_q;
	logic [STAT_W-1:0]     status_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic [DEV_W-1:0]      dev_q;
	logic [INO_W-1:0]      ino_q;
	logic [BLK_W-1:0]      blk_q;
	logic [OFF_W-1:0]      off_q;
	logic [INO_W-1:0]      rel;
	logic [BLK_W-1:0]      blk_d;

	// Inode numbers count from one; a zero number wraps before the split.
	assign rel      = res.inode - 1'b1;
	assign blk_d    = table_start + BLK_W'(rel >> OFF_W);
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	// Valid flag of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the output register.
	always_ff @(posedge clk) begin
		if (res_take) begin
			status_q <= res.status;
			slot_q   <= res.slot;
			dev_q    <= res.device;
			ino_q    <= res.inode;
			blk_q    <= res.with_block ? blk_d : '0;
			off_q    <= res.with_block ? rel[OFF_W-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot_out     = slot_q;
	assign device_out   = dev_q;
	assign inode_out    = ino_q;
	assign disk_block   = blk_q;
	assign block_offset = off_q;

endmodule

// File: rtl/inode_cache_table.sv
// Top level of the reference-counted inode cache table.
//
// Input channel (in_valid / in_stall): one transaction is a get (look up a
// device and inode number) or a put (release a slot, optionally marking it
// dirty). Output channel (out_valid / out_stall): exactly one result
// transaction per input transaction, in order. cfg_we / cfg_wdata set the
// first disk block of the inode table; write it only while the block is idle.
// A get reads the slot memory one slot per cycle through its single read
// port and stops at the first hit. A put reads, modifies and writes back
// one slot. One transaction is worked on at a time; in_stall is high from
// acceptance until the result has moved into the output register. The
// output register lets the next transaction be accepted while the previous
// result waits; if the receiver keeps stalling, the finished result is held
// and the input stays stalled.
// Reset clears all reference counts and dirty marks at once through per-slot
// valid bits, empties the output register and sets the table start to zero.
module inode_cache_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [ict_pkg::DEV_W-1:0]      device_id,
	input  logic [ict_pkg::INO_W-1:0]      inode_number,
	input  logic [ict_pkg::SLOT_OUT_W-1:0] slot_index,
	input  logic                           mark_dirty,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ict_pkg::STAT_W-1:0]     status,
	output logic [ict_pkg::SLOT_OUT_W-1:0] slot_out,
	output logic [ict_pkg::DEV_W-1:0]      device_out,
	output logic [ict_pkg::INO_W-1:0]      inode_out,
	output logic [ict_pkg::BLK_W-1:0]      disk_block,
	output logic [ict_pkg::OFF_W-1:0]      block_offset,
	input  logic                           cfg_we,
	input  logic [ict_pkg::BLK_W-1:0]      cfg_wdata
);
	import ict_pkg::*;

	logic [BLK_W-1:0] table_start_q;
	ict_rd_t          rd;
	ict_wr_t          wr;
	ict_entry_t       rd_data;
	ict_res_t         res;
	logic             res_valid;
	logic             res_take;

	// Inode table start register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_start_q <= '0;
		end else if (cfg_we) begin
			table_start_q <= cfg_wdata;
		end
	end

	// Slot memory.
	ict_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.wr      (wr),
		.rd_data (rd_data)
	);

	// Sequencer.
	ict_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.device_id    (device_id),
		.inode_number (inode_number),
		.slot_index   (slot_index),
		.mark_dirty   (mark_dirty),
		.rd           (rd),
		.wr           (wr),
		.rd_data      (rd_data),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take)
	);

	// Output register.
	ict_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take),
		.table_start  (table_start_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.slot_out     (slot_out),
		.device_out   (device_out),
		.inode_out    (inode_out),
		.disk_block   (disk_block),
		.block_offset (block_offset)
	);

endmodule

// File: rtl/ict_checker.sv
// Port-level checks of the inode cache table, bound to its top level.
module ict_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [ict_pkg::STAT_W-1:0]     status,
	input logic [ict_pkg::SLOT_OUT_W-1:0] slot_out,
	input logic [ict_pkg::DEV_W-1:0]      device_out,
	input logic [ict_pkg::INO_W-1:0]      inode_out,
	input logic [ict_pkg::BLK_W-1:0]      disk_block,
	input logic [ict_pkg::OFF_W-1:0]      block_offset
);
	import ict_pkg::*;

	// A stalled result transaction stays and keeps its status.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed or dropped");

	// Once a transaction is accepted the block is busy with it.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after acceptance");

	// Only defined status codes are reported.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_HIT) || (status == STAT_ALLOC) ||
			(status == STAT_FULL) || (status == STAT_HELD) ||
			(status == STAT_CLEAN) || (status == STAT_WRITE))
		else $error("undefined status code");

	// A full table reports nothing but its status.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_FULL) |->
			(slot_out == '0) && (device_out == '0) && (inode_out == '0) &&
			(disk_block == '0) && (block_offset == '0))
		else $error("full result carries data");

	// Only allocation and write back name a disk location.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == STAT_HIT) || (status == STAT_HELD) ||
			(status == STAT_CLEAN)) |-> (disk_block == '0) && (block_offset == '0))
		else $error("disk location reported without fetch or write back");

endmodule

bind inode_cache_table ict_checker u_ict_checker (.*);

// File: sim/ict_checker.sv
// Checker for the inode cache table: predicts every reply and compares it with the block's.
module ict_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           operation,
	input  logic [ict_pkg::DEV_W-1:0]      device_id,
	input  logic [ict_pkg::INO_W-1:0]      inode_number,
	input  logic [ict_pkg::SLOT_OUT_W-1:0] slot_index,
	input  logic                           mark_dirty,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [ict_pkg::STAT_W-1:0]     status,
	input  logic [ict_pkg::SLOT_OUT_W-1:0] slot_out,
	input  logic [ict_pkg::DEV_W-1:0]      device_out,
	input  logic [ict_pkg::INO_W-1:0]      inode_out,
	input  logic [ict_pkg::BLK_W-1:0]      disk_block,
	input  logic [ict_pkg::OFF_W-1:0]      block_offset,
	input  logic                           cfg_we,
	input  logic [ict_pkg::BLK_W-1:0]      cfg_wdata,
	output int                             errors,
	output int                             outstanding,
	output logic [ict_pkg::SLOTS-1:0]      claimed,
	output logic [ict_pkg::SLOTS-1:0]      live
);
	import ict_pkg::*;

	// One reply of the table as the block should present it.
	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [DEV_W-1:0]      device;
		logic [INO_W-1:0]      inode;
		logic [BLK_W-1:0]      block;
		logic [OFF_W-1:0]      offset;
	} cache_reply_t;

	localparam logic [INO_W-1:0] PER_BLOCK = INODES_PER_BLOCK;

	// Shadow copy of the slot table and the table start register.
	logic [CNT_W-1:0] refs [SLOTS];
	logic [DEV_W-1:0] owner_dev [SLOTS];
	logic [INO_W-1:0] owner_ino [SLOTS];
	logic             dirty [SLOTS];
	logic [BLK_W-1:0] table_start;
	logic [SLOTS-1:0] ever_claimed;
	logic [SLOTS-1:0] live_now;
	cache_reply_t     replies_due [$];
	cache_reply_t     oldest;
	int               fails;

	// Builds a reply; the disk position is only filled in where a transfer is due.
	function automatic cache_reply_t make_reply(input logic [STAT_W-1:0] st, input int slot,
		input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino, input logic with_block);
		cache_reply_t r;
		logic [INO_W-1:0] rel;
		rel = ino - 1'b1;
		r.status = st;
		r.slot   = SLOT_OUT_W'(slot);
		r.device = dev;
		r.inode  = ino;
		r.block  = with_block ? table_start + rel / PER_BLOCK : '0;
		r.offset = with_block ? OFF_W'(rel % PER_BLOCK) : '0;
		return r;
	endfunction

	// Applies one get or put to the shadow table and returns the reply it causes.
	function automatic cache_reply_t predict_reply(input logic op, input logic [DEV_W-1:0] dev,
		input logic [INO_W-1:0] ino, input logic [SLOT_OUT_W-1:0] slot, input logic md);
		int s;
		s = int'(slot);
		if (op == OP_GET) begin
			// A live slot holding the same inode is shared; its count saturates.
			for (int i = 0; i < SLOTS; i++) begin
				if (refs[i] != '0 && owner_dev[i] == dev && owner_ino[i] == ino) begin
					if (refs[i] != '1)
						refs[i] = refs[i] + 1'b1;
					return make_reply(STAT_HIT, i, dev, ino, 1'b0);
				end
			end
			// Otherwise the lowest free slot is claimed and must be fetched.
			for (int i = 0; i < SLOTS; i++) begin
				if (refs[i] == '0) begin
					refs[i] = CNT_W'(1);
					owner_dev[i] = dev;
					owner_ino[i] = ino;
					dirty[i] = 1'b0;
					ever_claimed[i] = 1'b1;
					return make_reply(STAT_ALLOC, i, dev, ino, 1'b1);
				end
			end
			return make_reply(STAT_FULL, 0, '0, '0, 1'b0);
		end
		if (s >= SLOTS)
			return make_reply(STAT_CLEAN, s, '0, '0, 1'b0);
		// A put releases one reference; the last one out writes a dirty slot back.
		if (refs[s] != '0)
			refs[s] = refs[s] - 1'b1;
		dirty[s] = dirty[s] | md;
		if (refs[s] != '0)
			return make_reply(STAT_HELD, s, owner_dev[s], owner_ino[s], 1'b0);
		if (dirty[s]) begin
			dirty[s] = 1'b0;
			return make_reply(STAT_WRITE, s, owner_dev[s], owner_ino[s], 1'b1);
		end
		return make_reply(STAT_CLEAN, s, owner_dev[s], owner_ino[s], 1'b0);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			fails++;
		end
	endtask

	// Replies are checked before the new transaction is predicted; both move at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				refs[i] = '0;
				owner_dev[i] = '0;
				owner_ino[i] = '0;
				dirty[i] = 1'b0;
			end
			table_start = '0;
			ever_claimed = '0;
			replies_due.delete();
			fails = 0;
			errors <= 0;
			outstanding <= 0;
			claimed <= '0;
			live <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$display("%0t: no reply expected, got status %0d slot %0d", $time,
						status, slot_out);
					fails++;
				end else begin
					oldest = replies_due.pop_front();
					check_field("status", 32'(oldest.status), 32'(status));
					check_field("slot_out", 32'(oldest.slot), 32'(slot_out));
					check_field("device_out", 32'(oldest.device), 32'(device_out));
					check_field("inode_out", oldest.inode, inode_out);
					check_field("disk_block", oldest.block, disk_block);
					check_field("block_offset", 32'(oldest.offset), 32'(block_offset));
				end
			end
			if (cfg_we)
				table_start = cfg_wdata;
			if (in_valid && !in_stall)
				replies_due.push_back(predict_reply(operation, device_id, inode_number,
					slot_index, mark_dirty));
			for (int i = 0; i < SLOTS; i++)
				live_now[i] = (refs[i] != '0);
			errors <= fails;
			outstanding <= replies_due.size();
			claimed <= ever_claimed;
			live <= live_now;
		end
	end

endmodule

// File: sim/tb_top.sv
// Testbench top for the inode cache table: stimulus, receiver stalls and the verdict.
module tb_top;
	import ict_pkg::*;

	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 66;
	localparam int REPEAT_GETS   = 4;
	localparam int POOL_SIZE     = 12;
	localparam int DRAIN_CYCLES  = SLOTS + 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  operation = OP_GET;
	logic [DEV_W-1:0]      device_id = '0;
	logic [INO_W-1:0]      inode_number = '0;
	logic [SLOT_OUT_W-1:0] slot_index = '0;
	logic                  mark_dirty = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STAT_W-1:0]     status;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [DEV_W-1:0]      device_out;
	logic [INO_W-1:0]      inode_out;
	logic [BLK_W-1:0]      disk_block;
	logic [OFF_W-1:0]      block_offset;
	logic                  cfg_we = 1'b0;
	logic [BLK_W-1:0]      cfg_wdata = '0;

	int               fail_count;
	int               replies_owed;
	logic [SLOTS-1:0] claimed_slots;
	logic [SLOTS-1:0] live_slots;
	int               src_idle_pct = 0;
	int               sink_stall_pct = 0;
	logic [DEV_W-1:0] pool_dev [POOL_SIZE];
	logic [INO_W-1:0] pool_ino [POOL_SIZE];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	inode_cache_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.device_id(device_id),
		.inode_number(inode_number),
		.slot_index(slot_index),
		.mark_dirty(mark_dirty),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot_out(slot_out),
		.device_out(device_out),
		.inode_out(inode_out),
		.disk_block(disk_block),
		.block_offset(block_offset),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	ict_scoreboard u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.device_id(device_id),
		.inode_number(inode_number),
		.slot_index(slot_index),
		.mark_dirty(mark_dirty),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot_out(slot_out),
		.device_out(device_out),
		.inode_out(inode_out),
		.disk_block(disk_block),
		.block_offset(block_offset),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors(fail_count),
		.outstanding(replies_owed),
		.claimed(claimed_slots),
		.live(live_slots)
	);

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= (sink_stall_pct != 0) && ($urandom_range(0, 99) < sink_stall_pct);
	end

	// Presents one transaction, after any random idle cycles, and waits until it is taken.
	task automatic issue_request(input logic op, input logic [DEV_W-1:0] dev,
		input logic [INO_W-1:0] ino, input logic [SLOT_OUT_W-1:0] slot, input logic md);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		device_id <= dev;
		inode_number <= ino;
		slot_index <= slot;
		mark_dirty <= md;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// The owed count is a registered copy, so it is trusted only from the next edge on.
	task automatic wait_idle();
		@(posedge clk);
		while (replies_owed != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_table_start(input logic [BLK_W-1:0] value);
		in_valid <= 1'b0;
		wait_idle();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly random inode numbers, with the extremes now and then.
	function automatic logic [INO_W-1:0] fresh_inode();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 1;
		if (roll == 1)
			return '1;
		return $urandom();
	endfunction

	// Gets often reuse a small pool of inodes so that hits are common; puts mostly release
	// slots still referenced and otherwise any slots that have been claimed before.
	task automatic random_request(input int get_pct);
		int pick;
		int start;
		logic [SLOTS-1:0] choices;
		logic [SLOT_OUT_W-1:0] slot;
		if ($urandom_range(0, 99) < get_pct) begin
			if ($urandom_range(0, 99) < 40) begin
				pick = $urandom_range(0, POOL_SIZE - 1);
				issue_request(OP_GET, pool_dev[pick], pool_ino[pick],
					SLOT_OUT_W'($urandom()), 1'($urandom()));
			end else begin
				issue_request(OP_GET, DEV_W'($urandom()), fresh_inode(),
					SLOT_OUT_W'($urandom()), 1'($urandom()));
			end
		end else begin
			choices = ($urandom_range(0, 99) < 80 && live_slots != '0) ? live_slots
				: claimed_slots;
			start = $urandom_range(0, SLOTS - 1);
			slot = '0;
			for (int k = SLOTS - 1; k >= 0; k--)
				if (choices[(start + k) % SLOTS])
					slot = SLOT_OUT_W'((start + k) % SLOTS);
			issue_request(OP_PUT, DEV_W'($urandom()), $urandom(), slot, 1'($urandom()));
		end
	endtask

	initial begin
		pool_dev[0] = 8'd7;
		pool_ino[0] = 32'd42;
		for (int i = 1; i < POOL_SIZE; i++) begin
			pool_dev[i] = DEV_W'($urandom_range(0, 3));
			pool_ino[i] = fresh_inode();
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_table_start(32'h0000_0100);

		// Claim slot 0 and hit it a few times, then release one reference dirty.
		for (int n = 0; n < REPEAT_GETS; n++)
			issue_request(OP_GET, 8'd7, 32'd42, SLOT_OUT_W'($urandom()), 1'($urandom()));
		issue_request(OP_PUT, 8'd0, 32'd0, 6'd0, 1'b1);

		// Field extremes, hits against near misses, and the inode number zero.
		issue_request(OP_GET, 8'd0, 32'd1, 6'd63, 1'b1);
		issue_request(OP_GET, 8'd255, 32'hFFFF_FFFF, 6'd0, 1'b0);
		issue_request(OP_GET, 8'd0, 32'd1, 6'd0, 1'b0);
		issue_request(OP_GET, 8'd255, 32'd1, 6'd0, 1'b0);
		issue_request(OP_GET, 8'd0, 32'd0, 6'd0, 1'b0);
		// Release down to zero, then puts on the slot once it is free.
		issue_request(OP_PUT, 8'd0, 32'd0, 6'd1, 1'b0);
		issue_request(OP_PUT, 8'd255, 32'hFFFF_FFFF, 6'd1, 1'b1);
		issue_request(OP_PUT, 8'd0, 32'd0, 6'd1, 1'b0);
		issue_request(OP_PUT, 8'd0, 32'd0, 6'd1, 1'b1);
		issue_request(OP_PUT, 8'd0, 32'd0, 6'd2, 1'b0);
		// Freed slots are claimed again lowest first.
		issue_request(OP_GET, 8'd0, 32'd9, 6'd0, 1'b0);
		issue_request(OP_GET, 8'd255, 32'hFFFF_FFFF, 6'd0, 1'b0);

		// The disk block wraps past the top of the block range.
		set_table_start('1);
		issue_request(OP_GET, 8'd1, 32'd17, 6'd0, 1'b0);
		issue_request(OP_PUT, 8'd0, 32'd0, 6'd5, 1'b1);

		// Fill every slot with random inodes until the table is full, then ask for more.
		set_table_start($urandom());
		while (live_slots != '1)
			issue_request(OP_GET, DEV_W'($urandom()), fresh_inode(),
				SLOT_OUT_W'($urandom()), 1'($urandom()));
		repeat (4) random_request(100);

		// Random phases alternate between draining and filling the table.
		for (int p = 0; p < PHASES; p++) begin
			set_table_start((p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF
				: (p == 4) ? 32'h1 : $urandom());
			case (p % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 88;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 88;
				end
				default: begin
					src_idle_pct = 34;
					sink_stall_pct = 34;
				end
			endcase
			repeat (PHASE_ITEMS) random_request((p % 2 == 0) ? 20 : 90);
		end

		in_valid <= 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && replies_owed == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
rtl/ict_pkg.sv
rtl/ict_mem.sv
rtl/ict_ctrl.sv
rtl/ict_out.sv
rtl/inode_cache_table.sv
rtl/ict_checker.sv
sim/ict_checker.sv
sim/tb_top.sv
